// ===== rtl/xcg_pkg.sv =====
// Shared constants, register codes and record types of the xbar group classifier.
`timescale 1ns / 1ps
package xcg_pkg;

	localparam int MAX_GROUP    = 1024;
	localparam int SAMPLE_WIDTH = 32;
	localparam int DATA_W       = 32;
	localparam int CNT_W        = 11;
	localparam int GRP_W        = 16;
	localparam int VERDICT_W    = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int SUM_W        = SAMPLE_WIDTH + CNT_W;
	localparam int MEAN_W       = SUM_W + 1;
	localparam int STEP_W       = $clog2(SUM_W);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CNT_W-1:0] MAX_GROUP_CNT = CNT_W'(MAX_GROUP);

	localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_CONTROL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_CONTROL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_WARNING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_WARNING = 3'd4;

	localparam logic [VERDICT_W-1:0] VERDICT_OK      = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_WARNING = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_CONTROL = 2'd2;

	localparam logic [CNT_W-1:0]         GROUP_SIZE_RST = 11'd5;
	localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [GRP_W-1:0]        grp;
		logic [CNT_W-1:0]        cnt;
		logic signed [SUM_W-1:0] sum;
	} group_rec_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] lower_control;
		logic signed [DATA_W-1:0] upper_control;
		logic signed [DATA_W-1:0] lower_warning;
		logic signed [DATA_W-1:0] upper_warning;
	} limits_t;

endpackage

// ===== rtl/xcg_ifs.sv =====
// Channel interfaces: sample input, group result output and configuration writes.
`timescale 1ns / 1ps
interface xcg_sample_if import xcg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample;
	logic                     end_of_data;

	modport source (output valid, output sample, output end_of_data, input ready);
	modport sink   (input valid, input sample, input end_of_data, output ready);
endinterface

interface xcg_result_if import xcg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [GRP_W-1:0]         group_number;
	logic [CNT_W-1:0]         sample_count;
	logic signed [DATA_W-1:0] group_mean;
	logic [VERDICT_W-1:0]     verdict;

	modport source (output valid, output group_number, output sample_count,
		output group_mean, output verdict, input ready);
	modport sink   (input valid, input group_number, input sample_count,
		input group_mean, input verdict, output ready);
endinterface

interface xcg_cfg_if import xcg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/xcg_front.sv =====
// Front end: accepts samples, keeps the running sum and count, closes groups.
`timescale 1ns / 1ps
module xcg_front import xcg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	xcg_sample_if.sink       samples,
	input  logic [CNT_W-1:0] group_size,
	input  logic             queue_full,
	output logic             push,
	output group_rec_t       push_rec
);

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [GRP_W-1:0]        grp_q;

	logic                        accept;
	logic [CNT_W-1:0]            size;
	logic signed [SAMPLE_WIDTH-1:0] s_w;
	logic signed [SUM_W-1:0]     s_ext;
	logic signed [SUM_W-1:0]     sum_nx;
	logic [CNT_W-1:0]            cnt_nx;
	logic                        close;

	assign samples.ready = !queue_full;
	assign accept        = samples.valid && samples.ready;

	// Zero means one; clamp to the largest group.
	always_comb begin
		if (group_size == '0) begin
			size = CNT_W'(1);
		end else if (group_size > MAX_GROUP_CNT) begin
			size = MAX_GROUP_CNT;
		end else begin
			size = group_size;
		end
	end

	assign s_w    = samples.sample[SAMPLE_WIDTH-1:0];
	assign s_ext  = {{(SUM_W-SAMPLE_WIDTH){s_w[SAMPLE_WIDTH-1]}}, s_w};
	assign sum_nx = sum_q + s_ext;
	assign cnt_nx = cnt_q + CNT_W'(1);
	assign close  = (cnt_nx >= size) || samples.end_of_data;

	assign push     = accept && close;
	assign push_rec = '{grp: grp_q, cnt: cnt_nx, sum: sum_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			grp_q <= GRP_W'(1);
		end else if (accept) begin
			if (close) begin
				sum_q <= '0;
				cnt_q <= '0;
				grp_q <= samples.end_of_data ? GRP_W'(1) : grp_q + GRP_W'(1);
			end else begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

	a_eod_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.end_of_data) |=> (grp_q == GRP_W'(1) && cnt_q == '0))
		else $error("end of data did not restart group numbering");

endmodule

// ===== rtl/xcg_queue.sv =====
// Short queue of closed groups between the front end and the divider.
`timescale 1ns / 1ps
module xcg_queue import xcg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  group_rec_t push_rec,
	output logic       full,
	input  logic       pop,
	output logic       rec_valid,
	output group_rec_t rec
);

	group_rec_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rec_valid = (count_q != '0);
	assign rec       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && rec_valid;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= QCNT_W'(QUEUE_DEPTH)) && !(push && full))
		else $error("queue pushed while full");

endmodule

// ===== rtl/xcg_back.sv =====
// Back end: serial divide of the group sum, sign restore, limit check, result register.
`timescale 1ns / 1ps
module xcg_back import xcg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rec_valid,
	input  group_rec_t rec,
	output logic       pop,
	input  limits_t    limits,
	xcg_result_if.source groups
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_SIGN  = 4'b0100,
		ST_JUDGE = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [SUM_W-1:0]         dq_q;
	logic [CNT_W-1:0]         rem_q;
	logic [CNT_W-1:0]         div_q;
	logic                     neg_q;
	logic [STEP_W-1:0]        step_q;
	logic [GRP_W-1:0]         grp_q;
	logic signed [MEAN_W-1:0] mean_q;

	logic                     out_valid_q;
	logic [GRP_W-1:0]         out_grp_q;
	logic [CNT_W-1:0]         out_cnt_q;
	logic [DATA_W-1:0]        out_mean_q;
	logic [VERDICT_W-1:0]     out_verdict_q;

	logic [CNT_W:0]           rem_sh;
	logic                     ge;
	logic [CNT_W:0]           rem_diff;
	logic                     out_free;
	logic                     load_out;
	logic [VERDICT_W-1:0]     verdict;
	logic signed [MEAN_W-1:0] lc, uc, lw, uw;

	assign pop = (state_q == ST_IDLE) && rec_valid;

	// One quotient bit per cycle.
	assign rem_sh   = {rem_q, dq_q[SUM_W-1]};
	assign ge       = (rem_sh >= {1'b0, div_q});
	assign rem_diff = rem_sh - {1'b0, div_q};

	assign lc = MEAN_W'(limits.lower_control);
	assign uc = MEAN_W'(limits.upper_control);
	assign lw = MEAN_W'(limits.lower_warning);
	assign uw = MEAN_W'(limits.upper_warning);

	// Control limits take precedence over warning limits.
	always_comb begin
		if (mean_q < lc || mean_q > uc) begin
			verdict = VERDICT_CONTROL;
		end else if (mean_q < lw || mean_q > uw) begin
			verdict = VERDICT_WARNING;
		end else begin
			verdict = VERDICT_OK;
		end
	end

	assign out_free = !out_valid_q || groups.ready;
	assign load_out = (state_q == ST_JUDGE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					state_q <= ST_JUDGE;
				end
				ST_JUDGE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			neg_q <= rec.sum[SUM_W-1];
			dq_q  <= rec.sum[SUM_W-1] ? (SUM_W'(0) - rec.sum) : rec.sum;
			rem_q <= '0;
			div_q <= rec.cnt;
			grp_q <= rec.grp;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], ge};
		end
		if (state_q == ST_SIGN) begin
			mean_q <= neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
		end
		if (load_out) begin
			out_grp_q     <= grp_q;
			out_cnt_q     <= div_q;
			out_mean_q    <= mean_q[DATA_W-1:0];
			out_verdict_q <= verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (groups.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign groups.valid        = out_valid_q;
	assign groups.group_number = out_grp_q;
	assign groups.sample_count = out_cnt_q;
	assign groups.group_mean   = out_mean_q;
	assign groups.verdict      = out_verdict_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");

	a_pop_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_DIV && step_q == '0))
		else $error("popped group did not start a divide");

endmodule

// ===== rtl/xbar_chart_group_classifier_top.sv =====
// Top level of the xbar control-chart group classifier: config registers and the three parts.
//
//   channel  | dir | payload                                            | handshake
//   ---------+-----+----------------------------------------------------+-------------
//   samples  | in  | sample[31:0] signed, end_of_data                   | valid/ready
//   groups   | out | group_number[15:0], sample_count[10:0],            | valid/ready
//            |     | group_mean[31:0] signed, verdict[1:0]              |
//   cfg      | in  | index[2:0], data[31:0]                             | valid/ready
//
// Samples enter at one per cycle while the group queue has room; each sample is summed
// in the cycle it is accepted. Every closed group passes the back end in order: it is
// taken from the queue, divided bit-serially (one quotient bit per cycle over the
// 43-bit sum), its sign is restored and its limits are checked, the check waiting
// while the result register still holds an untaken result. Reset clears sum, count
// and queue, sets the group number to one and loads the register defaults; there is
// no clearing pass. The front end stalls only when two closed groups wait in the
// queue; the result register lets the divider start the next group while a result
// waits to be taken.
`timescale 1ns / 1ps
module xbar_chart_group_classifier_top import xcg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	xcg_sample_if.sink   samples,
	xcg_result_if.source groups,
	xcg_cfg_if.sink      cfg
);

	logic [CNT_W-1:0] group_size_q;
	limits_t          limits_q;

	logic       cfg_wr;
	logic       push;
	group_rec_t push_rec;
	logic       queue_full;
	logic       pop;
	logic       rec_valid;
	group_rec_t rec;

	// Writes are always taken; an index past the register list is dropped.
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q           <= GROUP_SIZE_RST;
			limits_q.lower_control <= LIMIT_LOW_RST;
			limits_q.upper_control <= LIMIT_HIGH_RST;
			limits_q.lower_warning <= LIMIT_LOW_RST;
			limits_q.upper_warning <= LIMIT_HIGH_RST;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				REG_GROUP_SIZE:    group_size_q           <= cfg.data[CNT_W-1:0];
				REG_LOWER_CONTROL: limits_q.lower_control <= cfg.data;
				REG_UPPER_CONTROL: limits_q.upper_control <= cfg.data;
				REG_LOWER_WARNING: limits_q.lower_warning <= cfg.data;
				REG_UPPER_WARNING: limits_q.upper_warning <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Accumulate and close groups.
	xcg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.group_size (group_size_q),
		.queue_full (queue_full),
		.push       (push),
		.push_rec   (push_rec)
	);

	// Hold closed groups until the divider is free.
	xcg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (queue_full),
		.pop       (pop),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	// Divide, classify and present the result.
	xcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec),
		.pop       (pop),
		.limits    (limits_q),
		.groups    (groups)
	);

endmodule
